// ----- design/pfps_pkg.sv -----
// Shared types, field widths and codes of the portal funnel path smoother.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing.
package pfps_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int AREA_WIDTH  = PROD_WIDTH + 1;

   localparam int MODE_WIDTH     = 2;
   localparam int IN_DATA_WIDTH  = 4 * COORD_WIDTH;
   localparam int OUT_USED_WIDTH = 2 * COORD_WIDTH + 1;
   localparam int OUT_DATA_WIDTH = ((OUT_USED_WIDTH + 7) / 8) * 8;
   localparam int OUT_PAD_WIDTH  = OUT_DATA_WIDTH - OUT_USED_WIDTH;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [AREA_WIDTH-1:0]  area_type;
   typedef logic [MODE_WIDTH-1:0]         mode_type;

   // item modes
   localparam mode_type MODE_START  = 2'd0;
   localparam mode_type MODE_PORTAL = 2'd1;
   localparam mode_type MODE_DEST   = 2'd2;

   // result kinds
   localparam logic KIND_REPORT   = 1'b0;
   localparam logic KIND_WAYPOINT = 1'b1;

   // operand pairs of area(apex, b, c)
   typedef logic [1:0] xsel_type;
   localparam xsel_type XSEL_ORIENT = 2'd0;  // b = first end, c = second end
   localparam xsel_type XSEL_LEFT   = 2'd1;  // b = new left,  c = left
   localparam xsel_type XSEL_FUNNEL = 2'd2;  // b = right,     c = left
   localparam xsel_type XSEL_RIGHT  = 2'd3;  // b = right,     c = new right

   // point sources for apex loads and emitted waypoints
   typedef logic [1:0] psel_type;
   localparam psel_type PSEL_ZERO  = 2'd0;
   localparam psel_type PSEL_RIGHT = 2'd1;
   localparam psel_type PSEL_LEFT  = 2'd2;
   localparam psel_type PSEL_FIRST = 2'd3;

   typedef struct packed {
      logic     load_item;
      logic     mul_en;
      xsel_type xsel;
      logic     swap_ends;
      logic     upd_left;
      logic     upd_right;
      logic     open_portal;
      logic     open_swap;
      logic     apex_load;
      psel_type apex_sel;
      logic     emit;
      logic     emit_kind;
      psel_type emit_sel;
      logic     emit_swapped;
      logic     emit_last;
   } pfps_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     area_pos;
      logic     area_neg;
      logic     out_free;
   } pfps_sts_type;

   // sign-extending difference a - b
   function automatic diff_type cdiff(coord_type a, coord_type b);
      return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
   endfunction

endpackage

// ----- design/pfps_datapath.sv -----
// Datapath of the portal funnel path smoother: item, apex and funnel side
// registers, the shared cross-product multiplier pair and the result register.
// Depends on pfps_pkg.
module pfps_datapath
   import pfps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [IN_DATA_WIDTH-1:0]  req_tdata,
   input  mode_type                  req_tuser,
   input  pfps_cmd_type              cmd,
   output pfps_sts_type              sts,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [OUT_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   mode_type  mode_ff;
   coord_type fx_ff, fy_ff, sx_ff, sy_ff;
   coord_type apex_x_ff, apex_y_ff, left_x_ff, left_y_ff, right_x_ff, right_y_ff;
   coord_type apex_x_in, apex_y_in, left_x_in, left_y_in, right_x_in, right_y_in;
   prod_type  prod1_ff, prod2_ff, prod1_in, prod2_in;
   coord_type bx, by, cx, cy, lnew_x, lnew_y, rnew_x, rnew_y;
   coord_type in_fx, in_fy;
   diff_type  d1x, d1y, d2x, d2y;
   area_type  area;
   coord_type pt_x, pt_y, ap_x, ap_y;

   logic      out_valid_ff, out_kind_ff, out_swapped_ff, out_last_ff;
   coord_type out_x_ff, out_y_ff;
   logic      out_free;

   assign in_fx = req_tdata[COORD_WIDTH-1:0];
   assign in_fy = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

   // hold the item; a destination uses its point for both ends
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff <= req_tuser;
         fx_ff   <= in_fx;
         fy_ff   <= in_fy;
         if (req_tuser == MODE_DEST) begin
            sx_ff <= in_fx;
            sy_ff <= in_fy;
         end else begin
            sx_ff <= req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
            sy_ff <= req_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];
         end
      end
   end

   // oriented portal ends
   assign lnew_x = cmd.swap_ends ? fx_ff : sx_ff;
   assign lnew_y = cmd.swap_ends ? fy_ff : sy_ff;
   assign rnew_x = cmd.swap_ends ? sx_ff : fx_ff;
   assign rnew_y = cmd.swap_ends ? sy_ff : fy_ff;

   always_comb begin
      case (cmd.xsel)
         XSEL_ORIENT: begin
            bx = fx_ff;      by = fy_ff;      cx = sx_ff;     cy = sy_ff;
         end
         XSEL_LEFT: begin
            bx = lnew_x;     by = lnew_y;     cx = left_x_ff; cy = left_y_ff;
         end
         XSEL_FUNNEL: begin
            bx = right_x_ff; by = right_y_ff; cx = left_x_ff; cy = left_y_ff;
         end
         default: begin
            bx = right_x_ff; by = right_y_ff; cx = rnew_x;    cy = rnew_y;
         end
      endcase
   end

   assign d1x = cdiff(bx, apex_x_ff);
   assign d1y = cdiff(by, apex_y_ff);
   assign d2x = cdiff(cx, apex_x_ff);
   assign d2y = cdiff(cy, apex_y_ff);
   assign prod1_in = prod_type'(d1x) * prod_type'(d2y);
   assign prod2_in = prod_type'(d1y) * prod_type'(d2x);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
      end
   end

   assign area = {prod1_ff[PROD_WIDTH-1], prod1_ff} - {prod2_ff[PROD_WIDTH-1], prod2_ff};

   // point selection for waypoints (emit_sel) and for apex loads (apex_sel)
   always_comb begin
      case (cmd.emit_sel)
         PSEL_RIGHT: begin pt_x = right_x_ff; pt_y = right_y_ff; end
         PSEL_LEFT:  begin pt_x = left_x_ff;  pt_y = left_y_ff;  end
         PSEL_FIRST: begin pt_x = fx_ff;      pt_y = fy_ff;      end
         default:    begin pt_x = '0;         pt_y = '0;         end
      endcase
      case (cmd.apex_sel)
         PSEL_RIGHT: begin ap_x = right_x_ff; ap_y = right_y_ff; end
         PSEL_LEFT:  begin ap_x = left_x_ff;  ap_y = left_y_ff;  end
         PSEL_FIRST: begin ap_x = fx_ff;      ap_y = fy_ff;      end
         default:    begin ap_x = apex_x_ff;  ap_y = apex_y_ff;  end
      endcase
   end

   always_comb begin
      apex_x_in  = apex_x_ff;
      apex_y_in  = apex_y_ff;
      left_x_in  = left_x_ff;
      left_y_in  = left_y_ff;
      right_x_in = right_x_ff;
      right_y_in = right_y_ff;
      if (cmd.apex_load) begin
         apex_x_in = ap_x;
         apex_y_in = ap_y;
      end
      if (cmd.upd_left) begin
         left_x_in = lnew_x;
         left_y_in = lnew_y;
      end
      if (cmd.upd_right) begin
         right_x_in = rnew_x;
         right_y_in = rnew_y;
      end
      if (cmd.open_portal) begin
         if (cmd.open_swap) begin
            right_x_in = sx_ff; right_y_in = sy_ff;
            left_x_in  = fx_ff; left_y_in  = fy_ff;
         end else begin
            right_x_in = fx_ff; right_y_in = fy_ff;
            left_x_in  = sx_ff; left_y_in  = sy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         apex_x_ff  <= '0;
         apex_y_ff  <= '0;
         left_x_ff  <= '0;
         left_y_ff  <= '0;
         right_x_ff <= '0;
         right_y_ff <= '0;
      end else begin
         apex_x_ff  <= apex_x_in;
         apex_y_ff  <= apex_y_in;
         left_x_ff  <= left_x_in;
         left_y_ff  <= left_y_in;
         right_x_ff <= right_x_in;
         right_y_ff <= right_y_in;
      end
   end

   // result register: load on emit, drop when taken
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_kind_ff    <= cmd.emit_kind;
         out_x_ff       <= pt_x;
         out_y_ff       <= pt_y;
         out_swapped_ff <= cmd.emit_swapped;
         out_last_ff    <= cmd.emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{OUT_PAD_WIDTH{1'b0}}, out_swapped_ff, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   assign sts.mode     = mode_ff;
   assign sts.area_neg = area[AREA_WIDTH-1];
   assign sts.area_pos = !area[AREA_WIDTH-1] && (area != '0);
   assign sts.out_free = out_free;

endmodule

// ----- design/pfps_ctrl.sv -----
// Controller of the portal funnel path smoother: sequences the cross-product
// evaluations of one item and the results it emits.
// Depends on pfps_pkg.
module pfps_ctrl
   import pfps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  pfps_sts_type sts,
   output pfps_cmd_type cmd
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_DECODE  = 5'd1;
   localparam logic [4:0] ST_O_MUL   = 5'd2;
   localparam logic [4:0] ST_O_EV    = 5'd3;
   localparam logic [4:0] ST_L_MUL   = 5'd4;
   localparam logic [4:0] ST_L_EV    = 5'd5;
   localparam logic [4:0] ST_F1_MUL  = 5'd6;
   localparam logic [4:0] ST_F1_EV   = 5'd7;
   localparam logic [4:0] ST_R_MUL   = 5'd8;
   localparam logic [4:0] ST_R_EV    = 5'd9;
   localparam logic [4:0] ST_F2_MUL  = 5'd10;
   localparam logic [4:0] ST_F2_EV   = 5'd11;
   localparam logic [4:0] ST_RO_MUL  = 5'd12;
   localparam logic [4:0] ST_RO_EV   = 5'd13;
   localparam logic [4:0] ST_EMIT_WP = 5'd14;
   localparam logic [4:0] ST_EMIT_RP = 5'd15;
   localparam logic [4:0] ST_EMIT_DS = 5'd16;

   logic [4:0] state_ff, state_in;
   logic       open_ff, open_in;
   logic       a_ff, a_in;
   logic       report_sw_ff, report_sw_in;
   logic       corner_left_ff, corner_left_in;
   logic       nonpos;

   assign nonpos     = !sts.area_pos;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      open_in        = open_ff;
      a_in           = a_ff;
      report_sw_in   = report_sw_ff;
      corner_left_in = corner_left_ff;

      cmd              = '0;
      cmd.swap_ends    = a_ff;
      cmd.emit_swapped = report_sw_ff;

      case (state_ff)
         ST_IDLE: begin
            cmd.load_item = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.mode)
               MODE_START: begin
                  cmd.apex_load = 1'b1;
                  cmd.apex_sel  = PSEL_FIRST;
                  open_in       = 1'b0;
                  state_in      = ST_IDLE;
               end
               MODE_PORTAL: begin
                  state_in = ST_O_MUL;
               end
               MODE_DEST: begin
                  a_in     = 1'b0;
                  state_in = open_ff ? ST_L_MUL : ST_EMIT_DS;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_O_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.xsel   = XSEL_ORIENT;
            state_in   = ST_O_EV;
         end
         ST_O_EV: begin
            if (!open_ff) begin
               cmd.open_portal = 1'b1;
               cmd.open_swap   = nonpos;
               open_in         = 1'b1;
               report_sw_in    = nonpos;
               state_in        = ST_EMIT_RP;
            end else begin
               a_in     = nonpos;
               state_in = ST_L_MUL;
            end
         end
         ST_L_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.xsel   = XSEL_LEFT;
            state_in   = ST_L_EV;
         end
         ST_L_EV: begin
            cmd.upd_left = sts.area_pos;
            state_in     = ST_F1_MUL;
         end
         ST_F1_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.xsel   = XSEL_FUNNEL;
            state_in   = ST_F1_EV;
         end
         ST_F1_EV: begin
            if (sts.area_neg) begin
               corner_left_in = 1'b0;
               state_in       = ST_EMIT_WP;
            end else begin
               state_in = ST_R_MUL;
            end
         end
         ST_R_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.xsel   = XSEL_RIGHT;
            state_in   = ST_R_EV;
         end
         ST_R_EV: begin
            cmd.upd_right = sts.area_pos;
            state_in      = ST_F2_MUL;
         end
         ST_F2_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.xsel   = XSEL_FUNNEL;
            state_in   = ST_F2_EV;
         end
         ST_F2_EV: begin
            if (sts.area_neg) begin
               corner_left_in = 1'b1;
               state_in       = ST_EMIT_WP;
            end else if (sts.mode == MODE_DEST) begin
               state_in = ST_EMIT_DS;
            end else begin
               report_sw_in = a_ff;
               state_in     = ST_EMIT_RP;
            end
         end
         ST_EMIT_WP: begin
            // emit the crossed corner and move the apex onto it
            cmd.emit_kind    = KIND_WAYPOINT;
            cmd.emit_swapped = 1'b0;
            cmd.emit_sel     = corner_left_ff ? PSEL_LEFT : PSEL_RIGHT;
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.apex_load = 1'b1;
               cmd.apex_sel  = corner_left_ff ? PSEL_LEFT : PSEL_RIGHT;
               state_in      = (sts.mode == MODE_DEST) ? ST_EMIT_DS : ST_RO_MUL;
            end
         end
         ST_RO_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.xsel   = XSEL_ORIENT;
            state_in   = ST_RO_EV;
         end
         ST_RO_EV: begin
            cmd.open_portal = 1'b1;
            cmd.open_swap   = nonpos;
            report_sw_in    = a_ff ^ nonpos;
            state_in        = ST_EMIT_RP;
         end
         ST_EMIT_RP: begin
            cmd.emit_kind = KIND_REPORT;
            cmd.emit_sel  = PSEL_ZERO;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_DS: begin
            cmd.emit_kind    = KIND_WAYPOINT;
            cmd.emit_sel     = PSEL_FIRST;
            cmd.emit_swapped = 1'b0;
            cmd.emit_last    = 1'b1;
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.apex_load = 1'b1;
               cmd.apex_sel  = PSEL_FIRST;
               open_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         open_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         open_ff  <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff           <= a_in;
      report_sw_ff   <= report_sw_in;
      corner_left_ff <= corner_left_in;
   end

endmodule

// ----- design/portal_funnel_path_smoother.sv -----
// Top level of the portal funnel path smoother: joins the controller and the
// datapath. Depends on pfps_pkg, pfps_ctrl and pfps_datapath.
//
//   channel  | direction | ports               | word
//   ---------+-----------+---------------------+----------------------------------
//   request  | in        | req_tvalid/tready   | tuser mode, tdata four coordinates
//   response | out       | rsp_tvalid/tready   | tuser kind, tdata point and swap,
//            |           |                     | tlast on the destination waypoint
//
// One item is in work at a time; one shared multiplier pair evaluates every
// cross product in a multiply state and then an evaluate state. The response
// register frees the request side; a stalled response holds the item at its
// emit step. Reset (synchronous) empties the funnel, apex at origin.
module portal_funnel_path_smoother
   import pfps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // first_x, first_y, second_x, second_y
   input  logic [IN_DATA_WIDTH-1:0]  req_tdata,
   // mode
   input  mode_type                  req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // point_x, point_y, swapped, zero fill
   output logic [OUT_DATA_WIDTH-1:0] rsp_tdata,
   // kind
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   pfps_cmd_type cmd;
   pfps_sts_type sts;

   // sequence the cross products and emits of one word
   pfps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // hold funnel state, evaluate areas, register results
   pfps_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- design/pfps_checker.sv -----
// Port checker of the portal funnel path smoother and its bind to the top level.
// Depends on pfps_pkg.
module pfps_checker
   import pfps_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [OUT_DATA_WIDTH-1:0] rsp_tdata,
   input logic                      rsp_tuser,
   input logic                      rsp_tlast
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response word changed while stalled");

   // only a waypoint closes the path
   a_last_waypoint: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_WAYPOINT)
      else $error("last marker on a report");

   // a report carries no point and never ends the path
   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_REPORT |->
         rsp_tdata[2*COORD_WIDTH-1:0] == '0 && !rsp_tlast)
      else $error("report with point or last marker");

   // a waypoint carries no swap flag
   a_waypoint_noswap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_WAYPOINT |-> !rsp_tdata[2*COORD_WIDTH])
      else $error("swap flag on a waypoint");

   // reset drops any pending response
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind portal_funnel_path_smoother pfps_checker u_pfps_checker (.*);
